// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] entry_key;
      logic signed [31:0] entry_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] popped_value;
      logic signed [15:0] popped_key;
      logic [4:0]         entry_count;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } spq_state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } spq_cmd_type;

endpackage

// ----- src/spq_controller.sv -----
`timescale 1ns / 1ps

module spq_controller
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output spq_cmd_type cmd
);

   spq_state_type state_ff;
   spq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = start ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy      = 1'b0;
      rsp_valid = 1'b0;
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            cmd.load  = start;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec)
      else $error("accepted item not executed in next cycle");

   a_exec_then_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid && !busy)
      else $error("execution not followed by result strobe");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule

// ----- src/spq_datapath.sv -----
`timescale 1ns / 1ps

module spq_datapath
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  spq_cmd_type  cmd,
   input  req_item_type req_item,
   output rsp_item_type rsp_item
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   req_item_type       req_ff;
   rsp_item_type       rsp_ff;
   rsp_item_type       rsp_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic signed [15:0] key_ff   [CAPACITY];
   logic signed [31:0] value_ff [CAPACITY];
   logic signed [15:0] key_in   [CAPACITY];
   logic signed [31:0] value_in [CAPACITY];
   logic [CAPACITY-1:0] take;
   logic               full;
   logic               empty;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign do_push = (req_ff.mode == MODE_PUSH) && !full;
   assign do_pop  = (req_ff.mode == MODE_POP) && !empty;

   // a slot takes part in the insert if it is unused or holds a key not smaller;
   // the list is sorted, so this mask is a thermometer
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         take[i] = (CNT_W'(i) >= count_ff) || (key_ff[i] >= req_ff.entry_key);
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
      always_comb begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         if (do_push && take[i]) begin
            if (i == 0) begin
               key_in[i]   = req_ff.entry_key;
               value_in[i] = req_ff.entry_value;
            end else if (take[(i == 0) ? 0 : i - 1]) begin
               key_in[i]   = key_ff[(i == 0) ? 0 : i - 1];
               value_in[i] = value_ff[(i == 0) ? 0 : i - 1];
            end else begin
               key_in[i]   = req_ff.entry_key;
               value_in[i] = req_ff.entry_value;
            end
         end else if (do_pop && (i < CAPACITY - 1)) begin
            key_in[i]   = key_ff[(i < CAPACITY - 1) ? i + 1 : i];
            value_in[i] = value_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in            = count_ff;
      rsp_in.status       = STATUS_OK;
      rsp_in.popped_value = '0;
      rsp_in.popped_key   = '0;
      if (req_ff.mode == MODE_PUSH) begin
         if (full) rsp_in.status = STATUS_FULL;
         else      count_in      = count_ff + 1'b1;
      end else begin
         if (empty) begin
            rsp_in.status = STATUS_EMPTY;
         end else begin
            rsp_in.popped_value = value_ff[0];
            rsp_in.popped_key   = key_ff[0];
            count_in            = count_ff - 1'b1;
         end
      end
      rsp_in.entry_count = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_item;
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < CAPACITY; i++) begin
            key_ff[i]   <= key_in[i];
            value_ff[i] <= value_in[i];
         end
      end
   end

   assign rsp_item = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && do_push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("successful push did not add one entry");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && (req_ff.mode == MODE_POP) && empty |=>
         rsp_ff.status == STATUS_EMPTY && count_ff == '0)
      else $error("pop on empty queue misreported");

endmodule

// ----- src/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps

// Sequence: an accepted item is captured, then applied in the execute state, which
//   registers its result; rsp_valid strobes the result in the done state;
//   the strobe lasts one cycle and cannot be stalled.
// Busy is high only in execute, so a new item may be taken while a result is strobed;
//   there a push shifts up the slots picked by per-slot key compares; a pop shifts down.
// Reset: synchronous, active high; empties the queue and returns the controller to idle.
//   Stored keys and data are not cleared, only slots below the entry count are read.

module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   // Command bundle from the controller:
   //   load - capture the incoming item (start seen while not busy)
   //   exec - apply the captured push or pop to the list and register its result
   spq_cmd_type cmd;

   // Sequencer: idle -> execute -> done; a new item may be taken while the
   // previous result is on the strobe, so done can move straight to execute.
   spq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Sorted list of entries, smallest key in slot 0. A push shifts every slot
   // at or above the insert point up by one and drops the entry in the gap;
   // equal keys go ahead of older ones. A pop shifts the whole list down.
   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import spq_pkg::*;

   localparam int CAPACITY = 16;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   sorted_priority_queue_unit #(
      .CAPACITY(CAPACITY)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the queue: a sorted list, slot 0 holds the smallest key.
   logic signed [15:0] shadow_keys   [CAPACITY];
   logic signed [31:0] shadow_values [CAPACITY];
   int                 shadow_fill;

   // Results still owed by the block, oldest at the front.
   rsp_item_type awaited_results[$];

   int mismatch_count;
   int push_count;
   int drop_count;
   int pop_count;
   int empty_pop_count;
   int peak_fill;
   int burst_left;

   // Apply one item to the shadow queue and return the result it should produce.
   function automatic rsp_item_type predict_queue_item(req_item_type it);
      rsp_item_type r;
      int slot;
      r = '0;
      r.status = STATUS_OK;
      if (it.mode == MODE_PUSH) begin
         push_count++;
         if (shadow_fill >= CAPACITY) begin
            r.status = STATUS_FULL;
            drop_count++;
         end else begin
            // insert ahead of the first entry whose key is not smaller
            slot = 0;
            while (slot < shadow_fill && shadow_keys[slot] < it.entry_key)
               slot++;
            for (int j = shadow_fill; j > slot; j--) begin
               shadow_keys[j]   = shadow_keys[j-1];
               shadow_values[j] = shadow_values[j-1];
            end
            shadow_keys[slot]   = it.entry_key;
            shadow_values[slot] = it.entry_value;
            shadow_fill++;
            if (shadow_fill > peak_fill)
               peak_fill = shadow_fill;
         end
      end else begin
         pop_count++;
         if (shadow_fill == 0) begin
            r.status = STATUS_EMPTY;
            empty_pop_count++;
         end else begin
            r.popped_key   = shadow_keys[0];
            r.popped_value = shadow_values[0];
            for (int j = 1; j < shadow_fill; j++) begin
               shadow_keys[j-1]   = shadow_keys[j];
               shadow_values[j-1] = shadow_values[j];
            end
            shadow_fill--;
         end
      end
      r.entry_count = 5'(shadow_fill);
      return r;
   endfunction

   // Hold the item on the request ports until the block takes it, then record what
   // it owes. Start is only lowered when a gap follows, so back-to-back items keep it
   // high without a drop and re-raise in one time step.
   task automatic send_item(req_item_type it);
      start    <= 1'b1;
      req_item <= it;
      do
         @(posedge clock);
      while (busy);
      awaited_results.push_back(predict_queue_item(it));
      burst_left--;
      if (burst_left <= 0) begin
         // idle for a random stretch, then start a fresh burst
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
   endtask

   function automatic req_item_type make_item(logic mode, logic [15:0] key,
                                              logic [31:0] value);
      req_item_type it;
      it.mode        = mode;
      it.entry_key   = key;
      it.entry_value = value;
      return it;
   endfunction

   // Compare every result with the oldest expectation; sample at the edge so the
   // block's own updates at that edge are not yet visible.
   always @(posedge clock) begin
      rsp_item_type exp_r;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%t: result with nothing outstanding: status %0d value %0d key %0d count %0d",
                        $realtime, rsp_item.status, rsp_item.popped_value,
                        rsp_item.popped_key, rsp_item.entry_count);
         end else begin
            exp_r = awaited_results.pop_front();
            if (rsp_item.status !== exp_r.status
                || rsp_item.popped_value !== exp_r.popped_value
                || rsp_item.popped_key !== exp_r.popped_key
                || rsp_item.entry_count !== exp_r.entry_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t: mismatch: expected status %0d value %0d key %0d count %0d, got status %0d value %0d key %0d count %0d",
                           $realtime, exp_r.status, exp_r.popped_value, exp_r.popped_key,
                           exp_r.entry_count, rsp_item.status, rsp_item.popped_value,
                           rsp_item.popped_key, rsp_item.entry_count);
            end
         end
      end
   end

   // Pops on an empty queue straight after reset.
   task automatic test_empty_pop();
      send_item(make_item(MODE_POP, 16'h1234, 32'hDEADBEEF));
      send_item(make_item(MODE_POP, 16'h0000, 32'h00000000));
   endtask

   // Fill to capacity with extreme and repeated keys, push once more to see the entry
   // dropped, then pop a few to check ordering, including newest-first on equal keys.
   task automatic test_fill_and_overflow();
      logic [15:0] keys [CAPACITY];
      logic [31:0] values [CAPACITY];
      keys   = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0005, 16'h0005,
                 16'h0005, 16'h7FFF, 16'h8000, 16'h0064, 16'hFF9C, 16'h0001,
                 16'h0007, 16'h0007, 16'h0003, 16'h0002};
      values = '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF,
                 32'h00000051, 32'h00000052, 32'h00000053, 32'h55AA55AA,
                 32'hAA55AA55, 32'h00000064, 32'hFFFFFF9C, 32'h12345678,
                 32'h00000071, 32'h00000072, 32'h0F0F0F0F, 32'hF0F0F0F0};
      for (int i = 0; i < CAPACITY; i++)
         send_item(make_item(MODE_PUSH, keys[i], values[i]));
      send_item(make_item(MODE_PUSH, 16'h8000, 32'hFFFFFFFF));
      repeat (3) send_item(make_item(MODE_POP, 16'hFFFF, 32'hFFFFFFFF));
   endtask

   // Random traffic in segments that lean towards pushing, balance or popping, so the
   // queue keeps running into full and empty. Keys often fall in a narrow band to give
   // plenty of ties; fields of pops carry noise that the block must ignore.
   task automatic test_random_traffic(int n_items);
      int          push_pct;
      int          seg_left;
      logic        mode;
      logic [15:0] key;
      logic [15:0] corner_keys [4];
      corner_keys = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      seg_left = 0;
      push_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (seg_left == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 85;
               1: push_pct = 50;
               default: push_pct = 15;
            endcase
            seg_left = $urandom_range(10, 60);
         end
         seg_left--;
         mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
         case ($urandom_range(0, 3))
            0: key = 16'($urandom_range(0, 7)) - 16'd4;
            1: key = corner_keys[$urandom_range(0, 3)];
            default: key = 16'($urandom);
         endcase
         send_item(make_item(mode, key, $urandom));
      end
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      burst_left = 4;
      shadow_fill = 0;
      mismatch_count = 0;
      push_count = 0;
      drop_count = 0;
      pop_count = 0;
      empty_pop_count = 0;
      peak_fill = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_pop();
      test_fill_and_overflow();
      test_random_traffic(1530);

      start <= 1'b0;
      // drain outstanding results, then allow for the block's latency
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Ran %0d pushes (%0d dropped on full) and %0d pops (%0d on empty), peak fill %0d of %0d",
               push_count, drop_count, pop_count, empty_pop_count, peak_fill, CAPACITY);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("PASS sorted_priority_queue_unit");
      end else begin
         $display("FAIL sorted_priority_queue_unit");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2ms;
      $display("Timed out with %0d results outstanding", awaited_results.size());
      $display("FAIL sorted_priority_queue_unit");
      $finish;
   end

endmodule

// ----- sorted_priority_queue_unit.f -----
src/spq_pkg.sv
src/spq_controller.sv
src/spq_datapath.sv
src/sorted_priority_queue_unit.sv
verif/tb_top.sv
